### sv/md5_pkg.sv
`timescale 1ns / 1ps

package md5_pkg;

    // Request opcodes
    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_ADD_FIN = 2'd1;
    localparam logic [1:0] OP_FIN     = 2'd2;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_MARK     = 8'h80;
    localparam logic [6:0] BLK_BYTES    = 7'd64;
    localparam logic [5:0] LAST_LEN_POS = 6'd55;
    localparam logic [5:0] LAST_ROUND   = 6'd63;
    localparam logic [3:0] LEN_WORD_LO  = 4'd14;
    localparam logic [3:0] LEN_WORD_HI  = 4'd15;

    typedef logic [3:0][31:0] chain_t;

    // How the words of the block store are shaped while a block is compressed
    typedef struct packed {
        logic [6:0]  keep;      // bytes below this index come from the store
        logic        mark_en;   // place the 0x80 marker
        logic [5:0]  mark_pos;
        logic        len_en;    // words 14 and 15 carry the bit length
        logic [63:0] bit_len;
    } pad_desc_t;

    localparam logic [31:0] K_TAB [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Message word index used by a round
    function automatic logic [3:0] msg_idx(input logic [5:0] rnd);
        logic [3:0] r;
        logic [3:0] g;
        r = rnd[3:0];
        case (rnd[5:4])
            2'd0: g = r;
            2'd1: g = r + {r[1:0], 2'b00} + 4'd1;
            2'd2: g = r + {r[2:0], 1'b0} + 4'd5;
            2'd3: g = {r[0], 3'b000} - r;
            default: g = r;
        endcase
        return g;
    endfunction

    function automatic logic [4:0] rot_amt(input logic [5:0] rnd);
        logic [4:0] s;
        case ({rnd[5:4], rnd[1:0]})
            4'h0: s = 5'd7;
            4'h1: s = 5'd12;
            4'h2: s = 5'd17;
            4'h3: s = 5'd22;
            4'h4: s = 5'd5;
            4'h5: s = 5'd9;
            4'h6: s = 5'd14;
            4'h7: s = 5'd20;
            4'h8: s = 5'd4;
            4'h9: s = 5'd11;
            4'ha: s = 5'd16;
            4'hb: s = 5'd23;
            4'hc: s = 5'd6;
            4'hd: s = 5'd10;
            4'he: s = 5'd15;
            4'hf: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] t;
        t = {x, x} << n;
        return t[63:32];
    endfunction

    function automatic logic [31:0] bswap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

### sv/md5_blk_mem.sv
`timescale 1ns / 1ps

module md5_blk_mem (
    input  logic        aclk,
    input  logic        wr_en,
    input  logic [3:0]  wr_be,
    input  logic [3:0]  wr_addr,
    input  logic [31:0] wr_data,
    input  logic [3:0]  rd_addr,
    output logic [31:0] rd_data
);

    // 16 little-endian words of one 64-byte block
    logic [31:0] mem [16];
    logic [31:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            for (int k = 0; k < 4; k++) begin
                if (wr_be[k]) begin
                    mem[wr_addr][8*k +: 8] <= wr_data[8*k +: 8];
                end
            end
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/md5_core.sv
`timescale 1ns / 1ps

module md5_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  md5_pkg::pad_desc_t desc,
    input  logic              chain_init,
    output logic [3:0]        rd_addr,
    input  logic [31:0]       rd_data,
    output logic              busy,
    output logic              done,
    output md5_pkg::chain_t   chain
);

    import md5_pkg::*;

    logic        run_reg;
    logic        add_reg;
    logic [5:0]  rnd_reg;
    logic [3:0]  g_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    pad_desc_t   desc_reg;
    chain_t      chain_reg;

    logic [31:0] w_word;
    logic [31:0] f_val;
    logic [31:0] sum_val;
    logic [31:0] b_next;

    // Issue the read in the cycle before the round that uses it
    assign rd_addr = msg_idx(start ? 6'd0 : rnd_reg + 6'd1);

    // Shape the stored word into padding where the descriptor says so
    always_comb begin
        logic [5:0] p;
        w_word = '0;
        for (int k = 0; k < 4; k++) begin
            p = {g_reg, 2'(k)};
            if ({1'b0, p} < desc_reg.keep) begin
                w_word[8*k +: 8] = rd_data[8*k +: 8];
            end else if (desc_reg.mark_en && p == desc_reg.mark_pos) begin
                w_word[8*k +: 8] = PAD_MARK;
            end
        end
        if (desc_reg.len_en && g_reg == LEN_WORD_LO) begin
            w_word = desc_reg.bit_len[31:0];
        end else if (desc_reg.len_en && g_reg == LEN_WORD_HI) begin
            w_word = desc_reg.bit_len[63:32];
        end
    end

    always_comb begin
        case (rnd_reg[5:4])
            2'd0: f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1: f_val = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2: f_val = b_reg ^ c_reg ^ d_reg;
            2'd3: f_val = c_reg ^ (b_reg | ~d_reg);
            default: f_val = '0;
        endcase
        sum_val = a_reg + f_val + K_TAB[rnd_reg] + w_word;
        b_next  = b_reg + rotl32(sum_val, rot_amt(rnd_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg   <= 1'b0;
            add_reg   <= 1'b0;
            rnd_reg   <= '0;
            chain_reg <= {IV_D, IV_C, IV_B, IV_A};
        end else begin
            add_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                rnd_reg <= '0;
            end else if (run_reg) begin
                rnd_reg <= rnd_reg + 6'd1;
                if (rnd_reg == LAST_ROUND) begin
                    run_reg <= 1'b0;
                    add_reg <= 1'b1;
                end
            end
            if (add_reg) begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
            end else if (chain_init) begin
                chain_reg <= {IV_D, IV_C, IV_B, IV_A};
            end
        end
    end

    always_ff @(posedge aclk) begin
        g_reg <= rd_addr;
        if (start) begin
            desc_reg <= desc;
            a_reg    <= chain_reg[0];
            b_reg    <= chain_reg[1];
            c_reg    <= chain_reg[2];
            d_reg    <= chain_reg[3];
        end else if (run_reg) begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_next;
        end
    end

    assign busy  = run_reg | add_reg;
    assign done  = add_reg;
    assign chain = chain_reg;

endmodule

### sv/md5_message_digest_top.sv
`timescale 1ns / 1ps

// MD5 hash engine fed one message byte per request. s_opcode adds s_msg_byte (0), adds it and
// ends the message (1), or ends the message without a byte (2, also for empty messages);
// code 3 is dropped. Bytes go into a 16-word block store memory with a registered read port,
// and a single round unit walks the 64 rounds, one round per cycle, reading one message word
// from that memory each cycle. Padding is never written to the store: the round unit masks
// the word it reads and inserts the 0x80 marker and the bit length on the fly. A byte that
// does not complete a block leaves the engine ready for the next byte; the byte that completes
// a block is followed by the round unit's start, the 64 rounds, the chaining add and the return
// to idle. Ending a message compresses the padded block, then one more block when fewer than
// nine bytes of room remain, and then loads the digest. The digest waits in an
// output register; byte 0 of the digest sits in m_digest_first[63:56]. After the digest is
// taken into that register the chaining words and byte count return to their initial values.
// The byte count wraps modulo 2^64.
module md5_message_digest_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [7:0]  s_msg_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_digest_first,
    output logic [63:0] m_digest_second
);

    import md5_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BLK_GO,
        ST_WAIT_BLK,
        ST_PAD_GO,
        ST_WAIT_PAD,
        ST_TAIL_GO,
        ST_WAIT_TAIL,
        ST_EMIT
    } state_t;

    state_t      state_reg;
    logic [63:0] count_reg;
    logic        fin_pend_reg;
    logic        tail_reg;
    logic        m_valid_reg;
    logic [63:0] m_first_reg;
    logic [63:0] m_second_reg;

    logic        in_acc;
    logic        byte_wr;
    logic [5:0]  pos;
    logic        emit_load;
    logic        core_start;
    logic        core_busy;
    logic        core_done;
    logic [3:0]  rd_addr;
    logic [31:0] rd_data;
    pad_desc_t   desc;
    chain_t      chain;

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_acc    = s_valid && s_ready;
    assign pos       = count_reg[5:0];
    assign byte_wr   = in_acc && (s_opcode == OP_ADD || s_opcode == OP_ADD_FIN);
    // Load the digest once the output register is free or being drained
    assign emit_load = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign core_start = (state_reg == ST_BLK_GO) || (state_reg == ST_PAD_GO)
                     || (state_reg == ST_TAIL_GO);

    // Shape of the block about to be compressed
    always_comb begin
        desc          = '0;
        desc.bit_len  = {count_reg[60:0], 3'b000};
        case (state_reg)
            ST_BLK_GO: begin
                desc.keep = BLK_BYTES;
            end
            ST_PAD_GO: begin
                desc.keep     = {1'b0, pos};
                desc.mark_en  = 1'b1;
                desc.mark_pos = pos;
                desc.len_en   = (pos <= LAST_LEN_POS);
            end
            ST_TAIL_GO: begin
                desc.len_en = 1'b1;
            end
            default: begin
                desc.keep = BLK_BYTES;
            end
        endcase
    end

    md5_blk_mem u_mem (
        .aclk    (aclk),
        .wr_en   (byte_wr),
        .wr_be   (4'b0001 << pos[1:0]),
        .wr_addr (pos[5:2]),
        .wr_data ({4{s_msg_byte}}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    md5_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (core_start),
        .desc       (desc),
        .chain_init (emit_load),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .busy       (core_busy),
        .done       (core_done),
        .chain      (chain)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            fin_pend_reg <= 1'b0;
            tail_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            // Drop the digest once taken, unless a new one replaces it at this edge
            if (m_valid_reg && m_ready && !emit_load) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        case (s_opcode)
                            OP_ADD: begin
                                count_reg    <= count_reg + 64'd1;
                                fin_pend_reg <= 1'b0;
                                if (pos == LAST_ROUND) begin
                                    state_reg <= ST_BLK_GO;
                                end
                            end
                            OP_ADD_FIN: begin
                                count_reg    <= count_reg + 64'd1;
                                fin_pend_reg <= 1'b1;
                                state_reg    <= (pos == LAST_ROUND) ? ST_BLK_GO : ST_PAD_GO;
                            end
                            OP_FIN: begin
                                state_reg <= ST_PAD_GO;
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_BLK_GO: begin
                    state_reg <= ST_WAIT_BLK;
                end
                ST_WAIT_BLK: begin
                    if (core_done) begin
                        state_reg <= fin_pend_reg ? ST_PAD_GO : ST_IDLE;
                    end
                end
                ST_PAD_GO: begin
                    tail_reg  <= (pos > LAST_LEN_POS);
                    state_reg <= ST_WAIT_PAD;
                end
                ST_WAIT_PAD: begin
                    if (core_done) begin
                        state_reg <= tail_reg ? ST_TAIL_GO : ST_EMIT;
                    end
                end
                ST_TAIL_GO: begin
                    state_reg <= ST_WAIT_TAIL;
                end
                ST_WAIT_TAIL: begin
                    if (core_done) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (emit_load) begin
                        m_valid_reg  <= 1'b1;
                        count_reg    <= '0;
                        fin_pend_reg <= 1'b0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Digest payload: byte k of chaining word i is digest byte 4*i+k
    always_ff @(posedge aclk) begin
        if (emit_load) begin
            m_first_reg  <= {bswap32(chain[0]), bswap32(chain[1])};
            m_second_reg <= {bswap32(chain[2]), bswap32(chain[3])};
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_digest_first  = m_first_reg;
    assign m_digest_second = m_second_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        core_start |-> !core_busy)
        else $error("round unit started while busy");

    a_done_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        core_done |-> (state_reg == ST_WAIT_BLK || state_reg == ST_WAIT_PAD
                       || state_reg == ST_WAIT_TAIL))
        else $error("round unit finished with no block outstanding");

    a_valid_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_EMIT))
        else $error("digest shown without an emit step");

    a_count_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_load |=> (count_reg == 64'd0 && state_reg == ST_IDLE))
        else $error("byte count not restarted after digest");
`endif

endmodule
